>>> src/heq_pkg.sv
// Shared constants, codes and types for the histogram equalizer.
// No dependencies; every other file imports this package.
package heq_pkg;

   // Image and histogram sizing
   localparam int MAX_PIXELS = 262144;
   localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
   localparam int PIX_W      = 8;
   localparam int NBINS      = 256;
   localparam int LEVEL_MAX  = 255;

   // Rounded level: (diff * 510 + span) / (2 * span), quotient below 512
   localparam int QUOT_W     = 9;
   localparam int DEN_W      = CNT_W + 1;
   localparam int NUM_W      = CNT_W + 10;
   localparam int NUM_SCALE  = 2 * LEVEL_MAX;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ACCUM = 2'd1,
      CMD_BUILD = 2'd2,
      CMD_MAP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_DEGEN     = 2'd1,
      STAT_NOT_BUILT = 2'd2
   } status_type;

   // Control of the histogram bin store
   typedef struct packed {
      logic             clear;
      logic             rd_en;
      logic [PIX_W-1:0] rd_addr;
      logic             wr_en;
      logic [PIX_W-1:0] wr_addr;
      logic [CNT_W-1:0] wr_data;
   } bin_ctl_type;

endpackage

>>> src/heq_bins.sv
// Histogram bin store: one count per grey level, with per-bin valid bits
// so that reset and clear empty all bins at once. Depends on heq_pkg.
module heq_bins import heq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  bin_ctl_type      ctl,
   output logic [CNT_W-1:0] rd_data
);

   logic [CNT_W-1:0] bin_mem_ff [NBINS];
   logic [NBINS-1:0] valid_ff;
   logic [CNT_W-1:0] data_ff;
   logic             hit_ff;

   // Track which bins hold a written count
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.clear) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[ctl.wr_addr] <= 1'b1;
      end
   end

   // Write port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         bin_mem_ff[ctl.wr_addr] <= ctl.wr_data;
      end
   end

   // Registered read port; hold data until the next read
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         data_ff <= bin_mem_ff[ctl.rd_addr];
         hit_ff  <= valid_ff[ctl.rd_addr];
      end
   end

   // An empty bin reads as zero
   assign rd_data = hit_ff ? data_ff : '0;

endmodule

>>> src/heq_table.sv
// Level table: 256 equalized grey levels, one write and one registered
// read port. Depends on heq_pkg.
module heq_table import heq_pkg::*; (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [PIX_W-1:0] wr_addr,
   input  logic [PIX_W-1:0] wr_data,
   input  logic             rd_en,
   input  logic [PIX_W-1:0] rd_addr,
   output logic [PIX_W-1:0] rd_data
);

   logic [PIX_W-1:0] level_mem_ff [NBINS];
   logic [PIX_W-1:0] data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         level_mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; hold data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_ff <= level_mem_ff[rd_addr];
      end
   end

   assign rd_data = data_ff;

endmodule

>>> src/heq_div.sv
// Restoring divider, one quotient bit per cycle, for quotients below
// 2**QUOT_W. Depends on heq_pkg.
module heq_div import heq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   output logic              done,
   output logic [QUOT_W-1:0] quot
);

   localparam int STEP_W = $clog2(QUOT_W);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [QUOT_W-1:0] low_ff;
   logic [QUOT_W-1:0] quot_ff;
   logic [DEN_W-1:0]  den_ff;

   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    trial_sub;
   logic              fits;

   // Bring down the next numerator bit and try the subtraction
   assign trial     = {rem_ff, low_ff[QUOT_W-1]};
   assign trial_sub = trial - {1'b0, den_ff};
   assign fits      = trial >= {1'b0, den_ff};

   // Iterate one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            rem_ff  <= num[NUM_W-1:QUOT_W];
            low_ff  <= num[QUOT_W-1:0];
            den_ff  <= den;
         end else if (busy_ff) begin
            rem_ff  <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            low_ff  <= {low_ff[QUOT_W-2:0], 1'b0};
            quot_ff <= {quot_ff[QUOT_W-2:0], fits};
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(QUOT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

>>> src/histogram_equalizer.sv
// Histogram equalizer top level: command sequencer, bin store, level table, divider.
// Clear acts on accept; Accumulate reads the bin and writes it back incremented; Map
// reads the table into the result register. Build: the minimum search reads bins one
// by one; the table pass writes zero for each empty leading bin and otherwise uses the
// 9-step shared divider. One item at a time; the result register frees req_ready.
// Synchronous active-high reset empties the histogram and marks the table unbuilt.
module histogram_equalizer import heq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_command,
   input  logic [PIX_W-1:0] req_pixel,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [PIX_W-1:0] rsp_mapped_pixel,
   output logic [1:0]       rsp_status
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_ACC,
      S_MAP,
      S_B1_RD,
      S_B1_USE,
      S_CHK,
      S_B2_RD,
      S_B2_USE,
      S_B2_MUL,
      S_B2_DIV,
      S_PUT
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] count_ff;
   logic             built_ff;
   logic             degen_ff;
   logic [PIX_W-1:0] pix_ff;
   logic [CNT_W-1:0] run_ff;
   logic [CNT_W-1:0] cmin_ff;
   logic [CNT_W-1:0] span_ff;
   logic [CNT_W-1:0] diff_ff;
   logic [PIX_W-1:0] res_pix_ff;
   status_type       res_stat_ff;
   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_pix_ff;
   status_type       rsp_stat_ff;

   cmd_type           cmd;
   logic              accept;
   logic              room;
   logic              last_bin;
   logic              slot_free;
   logic [CNT_W-1:0]  run_in;
   logic              below;
   bin_ctl_type       bin_ctl;
   logic [CNT_W-1:0]  bin_rd;
   logic              tbl_wr_en;
   logic [PIX_W-1:0]  tbl_wr_data;
   logic              tbl_rd_en;
   logic [PIX_W-1:0]  tbl_rd;
   logic              div_start;
   logic [NUM_W-1:0]  div_num;
   logic              div_done;
   logic [QUOT_W-1:0] div_quot;
   logic [PIX_W-1:0]  level;

   // Decode the handshake and common conditions
   assign cmd       = cmd_type'(req_command);
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign room      = count_ff < CNT_W'(MAX_PIXELS);
   assign last_bin  = (pix_ff == '1);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign run_in    = run_ff + bin_rd;
   assign below     = run_in < cmin_ff;

   // Bin store control
   always_comb begin
      bin_ctl.clear   = accept && (cmd == CMD_CLEAR);
      bin_ctl.rd_en   = (accept && (cmd == CMD_ACCUM) && room)
                        || (state_ff == S_B1_RD) || (state_ff == S_B2_RD);
      bin_ctl.rd_addr = (state_ff == S_IDLE) ? req_pixel : pix_ff;
      bin_ctl.wr_en   = (state_ff == S_ACC);
      bin_ctl.wr_addr = pix_ff;
      bin_ctl.wr_data = bin_rd + 1'b1;
   end

   // Clamp the rounded quotient to the top grey level
   assign level = (div_quot > QUOT_W'(LEVEL_MAX)) ? PIX_W'(LEVEL_MAX)
                                                  : div_quot[PIX_W-1:0];

   // Level table control: zero below the minimum, else the divided level
   assign tbl_wr_en   = ((state_ff == S_B2_USE) && below)
                        || ((state_ff == S_B2_DIV) && div_done);
   assign tbl_wr_data = (state_ff == S_B2_USE) ? '0 : level;
   assign tbl_rd_en   = accept && (cmd == CMD_MAP);

   // Divider operands: (cdf - cmin) * 510 + span over 2 * span
   assign div_start = (state_ff == S_B2_MUL);
   assign div_num   = NUM_W'(diff_ff) * NUM_W'(NUM_SCALE) + NUM_W'(span_ff);

   heq_bins u_bins (
      .clock   (clock),
      .reset   (reset),
      .ctl     (bin_ctl),
      .rd_data (bin_rd)
   );

   heq_table u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (pix_ff),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (req_pixel),
      .rd_data (tbl_rd)
   );

   heq_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   ({span_ff, 1'b0}),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Sequencer, histogram state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         built_ff     <= 1'b0;
         degen_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == S_PUT) && slot_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_pix_ff   <= res_pix_ff;
            rsp_stat_ff  <= res_stat_ff;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  unique case (cmd)
                     CMD_CLEAR: begin
                        count_ff <= '0;
                        built_ff <= 1'b0;
                     end
                     CMD_ACCUM: begin
                        pix_ff <= req_pixel;
                        if (room) begin
                           state_ff <= S_ACC;
                        end
                     end
                     CMD_BUILD: begin
                        pix_ff   <= '0;
                        run_ff   <= '0;
                        cmin_ff  <= '0;
                        state_ff <= S_B1_RD;
                     end
                     CMD_MAP: begin
                        state_ff <= S_MAP;
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_ACC: begin
               count_ff <= count_ff + 1'b1;
               state_ff <= S_IDLE;
            end
            S_MAP: begin
               res_pix_ff  <= (built_ff && !degen_ff) ? tbl_rd : '0;
               res_stat_ff <= built_ff ? STAT_OK : STAT_NOT_BUILT;
               state_ff    <= S_PUT;
            end
            S_B1_RD: begin
               state_ff <= S_B1_USE;
            end
            S_B1_USE: begin
               // Stop at the first occupied bin; an empty histogram keeps zero
               run_ff <= run_in;
               if (run_in != '0) begin
                  cmin_ff  <= run_in;
                  state_ff <= S_CHK;
               end else if (last_bin) begin
                  state_ff <= S_CHK;
               end else begin
                  pix_ff   <= pix_ff + 1'b1;
                  state_ff <= S_B1_RD;
               end
            end
            S_CHK: begin
               built_ff   <= 1'b1;
               res_pix_ff <= '0;
               if (count_ff <= cmin_ff) begin
                  degen_ff    <= 1'b1;
                  res_stat_ff <= STAT_DEGEN;
                  state_ff    <= S_PUT;
               end else begin
                  degen_ff    <= 1'b0;
                  res_stat_ff <= STAT_OK;
                  span_ff     <= count_ff - cmin_ff;
                  run_ff      <= '0;
                  pix_ff      <= '0;
                  state_ff    <= S_B2_RD;
               end
            end
            S_B2_RD: begin
               state_ff <= S_B2_USE;
            end
            S_B2_USE: begin
               run_ff <= run_in;
               if (below) begin
                  if (last_bin) begin
                     state_ff <= S_PUT;
                  end else begin
                     pix_ff   <= pix_ff + 1'b1;
                     state_ff <= S_B2_RD;
                  end
               end else begin
                  diff_ff  <= run_in - cmin_ff;
                  state_ff <= S_B2_MUL;
               end
            end
            S_B2_MUL: begin
               state_ff <= S_B2_DIV;
            end
            S_B2_DIV: begin
               if (div_done) begin
                  if (last_bin) begin
                     state_ff <= S_PUT;
                  end else begin
                     pix_ff   <= pix_ff + 1'b1;
                     state_ff <= S_B2_RD;
                  end
               end
            end
            S_PUT: begin
               if (slot_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mapped_pixel = rsp_pix_ff;
   assign rsp_status       = rsp_stat_ff;

endmodule

>>> src/heq_checker.sv
// Port-level checks for histogram_equalizer, attached by bind.
// Depends on heq_pkg and the top level's port list.
module heq_props import heq_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic [1:0]       req_command,
   input logic [PIX_W-1:0] req_pixel,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [PIX_W-1:0] rsp_mapped_pixel,
   input logic [1:0]       rsp_status
);

   // Hold a stalled result item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mapped_pixel)
                                  && $stable(rsp_status))
      else $error("result item changed while stalled");

   // A non-ok status carries a zero level
   a_zero_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_OK) |-> rsp_mapped_pixel == '0)
      else $error("nonzero level with non-ok status");

   // Status is one of the defined codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STAT_OK) || (rsp_status == STAT_DEGEN)
                    || (rsp_status == STAT_NOT_BUILT))
      else $error("undefined status code");

   // A build item keeps the block busy after it is taken
   a_build_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command == CMD_BUILD) |=> !req_ready)
      else $error("ready right after a build item");

endmodule

bind histogram_equalizer heq_props u_heq_props (.*);
